@@ sv/fls_pkg.sv @@
package fls_pkg;

    // Widths of the word fields
    localparam int DATA_W        = 32;
    localparam int FAULT_BITS_DEF = 32;

    // Event codes
    localparam logic [2:0] ACT_BMS_FAULT = 3'd0;
    localparam logic [2:0] ACT_HV_FAULT  = 3'd1;
    localparam logic [2:0] ACT_WARNING   = 3'd2;
    localparam logic [2:0] ACT_CRITICAL  = 3'd3;
    localparam logic [2:0] ACT_STARTUP   = 3'd4;
    localparam logic [2:0] ACT_HV_RUN    = 3'd5;
    localparam logic [2:0] ACT_ACK       = 3'd6;
    localparam logic [2:0] ACT_STATUS    = 3'd7;

    // Reported system state codes
    localparam logic [2:0] SYS_CRITICAL = 3'd0;
    localparam logic [2:0] SYS_ERROR    = 3'd1;
    localparam logic [2:0] SYS_STARTING = 3'd2;
    localparam logic [2:0] SYS_READY    = 3'd3;
    localparam logic [2:0] SYS_RUNNING  = 3'd4;

    typedef struct packed {
        logic [2:0] action;
        logic [4:0] bit_index;
        logic       level;
    } t_in_word;

    typedef struct packed {
        logic [DATA_W-1:0] bms_active_out;
        logic [DATA_W-1:0] bms_latched_out;
        logic [DATA_W-1:0] hv_active_out;
        logic [DATA_W-1:0] hv_latched_out;
        logic [DATA_W-1:0] warnings_out;
        logic [2:0]        system_state;
        logic              safe_off_pulse;
        logic              ack_accepted;
        logic              hv_enable_allowed;
        logic              blocking_errors;
    } t_out_word;

endpackage

@@ sv/fls_core.sv @@
module fls_core #(
    parameter int FAULT_BITS = fls_pkg::FAULT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  fls_pkg::t_in_word i_word,
    output fls_pkg::t_out_word o_result
);

    logic [FAULT_BITS-1:0] r_bms_act, n_bms_act;
    logic [FAULT_BITS-1:0] r_bms_lat, n_bms_lat;
    logic [FAULT_BITS-1:0] r_hv_act, n_hv_act;
    logic [FAULT_BITS-1:0] r_hv_lat, n_hv_lat;
    logic [FAULT_BITS-1:0] r_warn, n_warn;
    logic                  r_crit, n_crit;
    logic                  r_start, n_start;
    logic                  r_hv_on, n_hv_on;

    logic                  in_range;
    logic [FAULT_BITS-1:0] bit_sel;
    logic                  pulse;
    logic                  acked;
    logic                  any_fault;
    logic [2:0]            sys_st;

    // Decode the selected bit
    assign in_range = (32'(i_word.bit_index) < FAULT_BITS);
    assign bit_sel  = in_range ? ((FAULT_BITS)'(1) << i_word.bit_index) : '0;

    // Apply the event to the current state
    always_comb begin
        n_bms_act = r_bms_act;
        n_bms_lat = r_bms_lat;
        n_hv_act  = r_hv_act;
        n_hv_lat  = r_hv_lat;
        n_warn    = r_warn;
        n_crit    = r_crit;
        n_start   = r_start;
        n_hv_on   = r_hv_on;
        pulse     = 1'b0;
        acked     = 1'b0;
        unique case (i_word.action)
            fls_pkg::ACT_BMS_FAULT: begin
                if (i_word.level) begin
                    pulse     = in_range && ((r_bms_act & bit_sel) == '0);
                    n_bms_act = r_bms_act | bit_sel;
                    n_bms_lat = r_bms_lat | bit_sel;
                end else begin
                    n_bms_act = r_bms_act & ~bit_sel;
                end
            end
            fls_pkg::ACT_HV_FAULT: begin
                if (i_word.level) begin
                    pulse    = in_range && ((r_hv_act & bit_sel) == '0);
                    n_hv_act = r_hv_act | bit_sel;
                    n_hv_lat = r_hv_lat | bit_sel;
                end else begin
                    n_hv_act = r_hv_act & ~bit_sel;
                end
            end
            fls_pkg::ACT_WARNING: begin
                if (i_word.level) begin
                    n_warn = r_warn | bit_sel;
                end else begin
                    n_warn = r_warn & ~bit_sel;
                end
            end
            fls_pkg::ACT_CRITICAL: begin
                n_crit = 1'b1;
                pulse  = 1'b1;
            end
            fls_pkg::ACT_STARTUP: begin
                n_start = i_word.level;
            end
            fls_pkg::ACT_HV_RUN: begin
                n_hv_on = i_word.level;
            end
            fls_pkg::ACT_ACK: begin
                if (!r_crit && ((r_bms_act | r_hv_act) == '0)) begin
                    n_bms_lat = '0;
                    n_hv_lat  = '0;
                    n_warn    = '0;
                    acked     = 1'b1;
                end
            end
            fls_pkg::ACT_STATUS: begin
            end
            default: begin
            end
        endcase
    end

    // Derive the reported state from the updated masks
    assign any_fault = ((n_bms_act | n_bms_lat | n_hv_act | n_hv_lat) != '0);

    always_comb begin
        if (n_crit) begin
            sys_st = fls_pkg::SYS_CRITICAL;
        end else if (any_fault) begin
            sys_st = fls_pkg::SYS_ERROR;
        end else if (!n_start) begin
            sys_st = fls_pkg::SYS_STARTING;
        end else if (n_hv_on) begin
            sys_st = fls_pkg::SYS_RUNNING;
        end else begin
            sys_st = fls_pkg::SYS_READY;
        end
    end

    // Build the result word
    always_comb begin
        o_result.bms_active_out    = fls_pkg::DATA_W'(n_bms_act);
        o_result.bms_latched_out   = fls_pkg::DATA_W'(n_bms_lat);
        o_result.hv_active_out     = fls_pkg::DATA_W'(n_hv_act);
        o_result.hv_latched_out    = fls_pkg::DATA_W'(n_hv_lat);
        o_result.warnings_out      = fls_pkg::DATA_W'(n_warn);
        o_result.system_state      = sys_st;
        o_result.safe_off_pulse    = pulse;
        o_result.ack_accepted      = acked;
        o_result.hv_enable_allowed = !n_crit && n_start && !any_fault;
        o_result.blocking_errors   = n_crit || any_fault;
    end

    // Commit the state when the word moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bms_act <= '0;
            r_bms_lat <= '0;
            r_hv_act  <= '0;
            r_hv_lat  <= '0;
            r_warn    <= '0;
            r_crit    <= 1'b0;
            r_start   <= 1'b0;
            r_hv_on   <= 1'b0;
        end else if (i_en) begin
            r_bms_act <= n_bms_act;
            r_bms_lat <= n_bms_lat;
            r_hv_act  <= n_hv_act;
            r_hv_lat  <= n_hv_lat;
            r_warn    <= n_warn;
            r_crit    <= n_crit;
            r_start   <= n_start;
            r_hv_on   <= n_hv_on;
        end
    end

    // Latched masks always cover the active ones
    a_lat_covers_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_bms_act & ~r_bms_lat) == '0) && ((r_hv_act & ~r_hv_lat) == '0))
        else $error("active fault bit without latched bit");

    // Critical is left only by reset
    a_crit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_crit |=> r_crit)
        else $error("critical flag dropped");

    // An accepted acknowledge leaves no latch behind
    a_ack_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && acked) |=> (r_bms_lat == '0) && (r_hv_lat == '0) && (r_warn == '0))
        else $error("acknowledge left latched bits");

endmodule

@@ sv/fault_latch_supervisor.sv @@
// Fault latch supervisor.
// Input channel: i_valid / o_stall carry one event word (action, bit_index,
// level). A word is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one result word per event with the
// fault masks, warnings and derived system state after that event.
// A taken word passes from the input register through the state update into
// the result register, and waits while a stalled result holds that slot.
// Throughput: one event per cycle while i_stall is low, set by the single
// state update that each word performs as it enters the result register.
// The block holds one word in the input register while a result waits, so
// it keeps taking words until both registers are full; then o_stall rises
// and nothing moves until i_stall drops. Held words and results stay stable.
// Reset (synchronous, active low) clears all masks and flags and empties
// both registers.
module fault_latch_supervisor #(
    parameter int FAULT_BITS = fls_pkg::FAULT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  fls_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_stall,
    output fls_pkg::t_out_word o_word
);

    logic               r_in_valid;
    fls_pkg::t_in_word  r_in;
    logic               r_out_valid;
    fls_pkg::t_out_word r_out;
    fls_pkg::t_out_word result;
    logic               adv_out;
    logic               load_in;

    // Move the held word into the result register when that slot frees up
    assign adv_out = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !adv_out;
    assign load_in = i_valid && !o_stall;

    fls_core #(
        .FAULT_BITS(FAULT_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv_out),
        .i_word  (r_in),
        .o_result(result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load_in) begin
            r_in_valid <= 1'b1;
        end else if (adv_out) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_in <= i_word;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    // Stall only when a word is held that cannot move on
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("stall raised with a free slot");

    // Allowed to enable high voltage means nothing is blocking
    a_hv_vs_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_word.hv_enable_allowed && o_word.blocking_errors))
        else $error("enable allowed while blocking errors exist");

    // Accepted acknowledge reports no faults at all
    a_ack_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.ack_accepted) |->
            (o_word.system_state != fls_pkg::SYS_CRITICAL) &&
            (o_word.system_state != fls_pkg::SYS_ERROR))
        else $error("acknowledge accepted in a fault state");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int FAULT_BITS   = fls_pkg::FAULT_BITS_DEF;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 200000;

    // One directed row: the event word and, where obvious, its status word
    typedef struct packed {
        fls_pkg::t_in_word  ev;
        logic               typed;
        fls_pkg::t_out_word res;
    } t_dir_row;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    fls_pkg::t_in_word  i_word  = '0;
    logic               o_stall;
    logic               o_valid;
    fls_pkg::t_out_word o_word;

    fault_latch_supervisor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    // Supervisor image kept by the testbench
    logic [31:0] bms_act, bms_lat, hv_act, hv_lat, warn_bits;
    logic        crit_seen, started, hv_run;

    t_dir_row           dir_rows[$];
    t_dir_row           row_plan_q[$];
    fls_pkg::t_out_word status_q[$];
    t_dir_row           cur_plan;
    fls_pkg::t_out_word want;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int err_cnt       = 0;
    int sent_cnt      = 0;
    int checked_cnt   = 0;
    int ack_cnt       = 0;
    int pulse_cnt     = 0;
    int cycle_cnt     = 0;
    int crit_row_idx  = 0;

    // Free-running clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Advance the supervisor image by one event and return its status word
    function automatic fls_pkg::t_out_word apply_event(fls_pkg::t_in_word ev);
        fls_pkg::t_out_word r;
        logic [31:0]        b;
        logic [31:0]        any;
        logic               in_rng;
        logic               pulse;
        logic               acked;
        in_rng = (int'(ev.bit_index) < FAULT_BITS);
        b      = in_rng ? (32'd1 << ev.bit_index) : 32'd0;
        pulse  = 1'b0;
        acked  = 1'b0;
        case (ev.action)
            fls_pkg::ACT_BMS_FAULT: begin
                if (in_rng) begin
                    pulse = ev.level && ((bms_act & b) == 32'd0);
                    if (ev.level) begin
                        bms_act = bms_act | b;
                        bms_lat = bms_lat | b;
                    end else begin
                        bms_act = bms_act & ~b;
                    end
                end
            end
            fls_pkg::ACT_HV_FAULT: begin
                if (in_rng) begin
                    pulse = ev.level && ((hv_act & b) == 32'd0);
                    if (ev.level) begin
                        hv_act = hv_act | b;
                        hv_lat = hv_lat | b;
                    end else begin
                        hv_act = hv_act & ~b;
                    end
                end
            end
            fls_pkg::ACT_WARNING: begin
                if (in_rng) begin
                    warn_bits = ev.level ? (warn_bits | b) : (warn_bits & ~b);
                end
            end
            fls_pkg::ACT_CRITICAL: begin
                crit_seen = 1'b1;
                pulse     = 1'b1;
            end
            fls_pkg::ACT_STARTUP: started = ev.level;
            fls_pkg::ACT_HV_RUN:  hv_run  = ev.level;
            fls_pkg::ACT_ACK: begin
                // Clear latches only when nothing critical or active remains
                if (!crit_seen && (bms_act | hv_act) == 32'd0) begin
                    bms_lat   = 32'd0;
                    hv_lat    = 32'd0;
                    warn_bits = 32'd0;
                    acked     = 1'b1;
                end
            end
            default: ;
        endcase

        any = bms_act | bms_lat | hv_act | hv_lat;
        r.bms_active_out  = bms_act;
        r.bms_latched_out = bms_lat;
        r.hv_active_out   = hv_act;
        r.hv_latched_out  = hv_lat;
        r.warnings_out    = warn_bits;
        if (crit_seen)
            r.system_state = fls_pkg::SYS_CRITICAL;
        else if (any != 32'd0)
            r.system_state = fls_pkg::SYS_ERROR;
        else if (!started)
            r.system_state = fls_pkg::SYS_STARTING;
        else
            r.system_state = hv_run ? fls_pkg::SYS_RUNNING : fls_pkg::SYS_READY;
        r.safe_off_pulse    = pulse;
        r.ack_accepted      = acked;
        r.hv_enable_allowed = !crit_seen && started && (any == 32'd0);
        r.blocking_errors   = crit_seen || (any != 32'd0);
        return r;
    endfunction

    // Build a status word with the high-voltage group and warnings clear
    function automatic fls_pkg::t_out_word bms_status(logic [31:0] act, logic [31:0] lat,
                                                      logic [2:0] st, logic pulse,
                                                      logic acked, logic hv_en,
                                                      logic blk);
        fls_pkg::t_out_word r;
        r = '0;
        r.bms_active_out    = act;
        r.bms_latched_out   = lat;
        r.system_state      = st;
        r.safe_off_pulse    = pulse;
        r.ack_accepted      = acked;
        r.hv_enable_allowed = hv_en;
        r.blocking_errors   = blk;
        return r;
    endfunction

    function automatic fls_pkg::t_in_word make_event(logic [2:0] act, int idx, logic lvl);
        fls_pkg::t_in_word ev;
        ev.action    = act;
        ev.bit_index = 5'(idx);
        ev.level     = lvl;
        return ev;
    endfunction

    // Random event; critical stays out unless asked for, since it never clears
    function automatic fls_pkg::t_in_word noise_event(bit allow_crit);
        fls_pkg::t_in_word ev;
        ev.action    = 3'($urandom_range(7));
        ev.bit_index = 5'($urandom_range(31));
        ev.level     = 1'($urandom_range(1));
        if (!allow_crit && ev.action == fls_pkg::ACT_CRITICAL)
            ev.action = fls_pkg::ACT_STATUS;
        return ev;
    endfunction

    task automatic add_row(logic [2:0] act, int idx, logic lvl, logic typed,
                           fls_pkg::t_out_word res);
        t_dir_row row;
        row.ev    = make_event(act, idx, lvl);
        row.typed = typed;
        row.res   = res;
        dir_rows.push_back(row);
    endtask

    // Offer one event word, idling first at random, and hold it until taken
    task automatic send_event(fls_pkg::t_in_word ev, logic typed, fls_pkg::t_out_word res);
        t_dir_row plan;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        plan.ev    = ev;
        plan.typed = typed;
        plan.res   = res;
        row_plan_q.push_back(plan);
        i_valid <= 1'b1;
        i_word  <= ev;
        sent_cnt++;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Raise a few faults, clear them again (mostly all of them), then acknowledge
    task automatic run_episode();
        fls_pkg::t_in_word raised[$];
        fls_pkg::t_in_word ev;
        int                n;
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
            ev = make_event($urandom_range(1) ? fls_pkg::ACT_BMS_FAULT
                                              : fls_pkg::ACT_HV_FAULT,
                            $urandom_range(1) ? $urandom_range(3) : $urandom_range(31),
                            1'b1);
            send_event(ev, 1'b0, '0);
            raised.push_back(ev);
            if ($urandom_range(2) == 0)
                send_event(noise_event(1'b0), 1'b0, '0);
        end
        if ($urandom_range(3) == 0)
            send_event(make_event(fls_pkg::ACT_ACK, $urandom_range(31),
                                  1'($urandom_range(1))),
                       1'b0, '0);
        foreach (raised[k]) begin
            ev       = raised[k];
            ev.level = 1'b0;
            if ($urandom_range(9) != 0)
                send_event(ev, 1'b0, '0);
        end
        send_event(make_event(fls_pkg::ACT_ACK, $urandom_range(31), 1'($urandom_range(1))),
                   1'b0, '0);
        if ($urandom_range(1) == 0)
            send_event(make_event($urandom_range(1) ? fls_pkg::ACT_STARTUP
                                                    : fls_pkg::ACT_HV_RUN,
                                  $urandom_range(31), 1'($urandom_range(1))),
                       1'b0, '0);
    endtask

    task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            err_cnt++;
        end
    endtask

    task automatic check_status(fls_pkg::t_out_word e, fls_pkg::t_out_word a);
        cmp_field("bms_active_out", e.bms_active_out, a.bms_active_out);
        cmp_field("bms_latched_out", e.bms_latched_out, a.bms_latched_out);
        cmp_field("hv_active_out", e.hv_active_out, a.hv_active_out);
        cmp_field("hv_latched_out", e.hv_latched_out, a.hv_latched_out);
        cmp_field("warnings_out", e.warnings_out, a.warnings_out);
        cmp_field("system_state", 32'(e.system_state), 32'(a.system_state));
        cmp_field("safe_off_pulse", 32'(e.safe_off_pulse), 32'(a.safe_off_pulse));
        cmp_field("ack_accepted", 32'(e.ack_accepted), 32'(a.ack_accepted));
        cmp_field("hv_enable_allowed", 32'(e.hv_enable_allowed),
                  32'(a.hv_enable_allowed));
        cmp_field("blocking_errors", 32'(e.blocking_errors), 32'(a.blocking_errors));
    endtask

    // Randomize the result-side stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < snk_stall_pct);
    end

    // Check taken results, then predict for the word taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (status_q.size() == 0) begin
                    $error("result word with no event pending");
                    err_cnt++;
                end else begin
                    want = status_q.pop_front();
                    check_status(want, o_word);
                    checked_cnt++;
                    if (o_word.ack_accepted)   ack_cnt++;
                    if (o_word.safe_off_pulse) pulse_cnt++;
                end
            end
            if (i_valid && !o_stall) begin
                cur_plan = row_plan_q.pop_front();
                want     = apply_event(i_word);
                status_q.push_back(cur_plan.typed ? cur_plan.res : want);
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_cnt, status_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int phase_end;
        bms_act   = '0;
        bms_lat   = '0;
        hv_act    = '0;
        hv_lat    = '0;
        warn_bits = '0;
        crit_seen = 1'b0;
        started   = 1'b0;
        hv_run    = 1'b0;

        // Directed rows: idle supervisor, startup, faults at both ends of the mask
        add_row(fls_pkg::ACT_STATUS, 0, 1'b0, 1'b1,
                bms_status(32'd0, 32'd0, fls_pkg::SYS_STARTING,
                           1'b0, 1'b0, 1'b0, 1'b0));
        add_row(fls_pkg::ACT_ACK, 0, 1'b0, 1'b1,
                bms_status(32'd0, 32'd0, fls_pkg::SYS_STARTING,
                           1'b0, 1'b1, 1'b0, 1'b0));
        add_row(fls_pkg::ACT_STARTUP, 0, 1'b1, 1'b1,
                bms_status(32'd0, 32'd0, fls_pkg::SYS_READY,
                           1'b0, 1'b0, 1'b1, 1'b0));
        add_row(fls_pkg::ACT_HV_RUN, 0, 1'b1, 1'b1,
                bms_status(32'd0, 32'd0, fls_pkg::SYS_RUNNING,
                           1'b0, 1'b0, 1'b1, 1'b0));
        add_row(fls_pkg::ACT_BMS_FAULT, 0, 1'b1, 1'b1,
                bms_status(32'd1, 32'd1, fls_pkg::SYS_ERROR,
                           1'b1, 1'b0, 1'b0, 1'b1));
        add_row(fls_pkg::ACT_BMS_FAULT, 0, 1'b1, 1'b0, '0);
        add_row(fls_pkg::ACT_BMS_FAULT, 31, 1'b1, 1'b0, '0);
        add_row(fls_pkg::ACT_HV_FAULT, 31, 1'b1, 1'b0, '0);
        add_row(fls_pkg::ACT_HV_FAULT, 0, 1'b1, 1'b0, '0);
        add_row(fls_pkg::ACT_WARNING, 31, 1'b1, 1'b0, '0);
        add_row(fls_pkg::ACT_WARNING, 0, 1'b1, 1'b0, '0);
        add_row(fls_pkg::ACT_ACK, 31, 1'b1, 1'b0, '0);
        add_row(fls_pkg::ACT_BMS_FAULT, 0, 1'b0, 1'b0, '0);
        add_row(fls_pkg::ACT_BMS_FAULT, 31, 1'b0, 1'b0, '0);
        add_row(fls_pkg::ACT_HV_FAULT, 31, 1'b0, 1'b0, '0);
        add_row(fls_pkg::ACT_HV_FAULT, 0, 1'b0, 1'b0, '0);
        add_row(fls_pkg::ACT_ACK, 0, 1'b0, 1'b1,
                bms_status(32'd0, 32'd0, fls_pkg::SYS_RUNNING,
                           1'b0, 1'b1, 1'b1, 1'b0));
        add_row(fls_pkg::ACT_WARNING, 5, 1'b1, 1'b0, '0);
        add_row(fls_pkg::ACT_WARNING, 5, 1'b0, 1'b0, '0);
        add_row(fls_pkg::ACT_HV_RUN, 0, 1'b0, 1'b0, '0);
        add_row(fls_pkg::ACT_STARTUP, 0, 1'b0, 1'b0, '0);
        add_row(fls_pkg::ACT_STATUS, 31, 1'b1, 1'b1,
                bms_status(32'd0, 32'd0, fls_pkg::SYS_STARTING,
                           1'b0, 1'b0, 1'b0, 1'b0));
        // Critical rows run after the random part, since critical never clears
        crit_row_idx = dir_rows.size();
        add_row(fls_pkg::ACT_CRITICAL, 0, 1'b0, 1'b0, '0);
        add_row(fls_pkg::ACT_CRITICAL, 31, 1'b1, 1'b0, '0);
        add_row(fls_pkg::ACT_ACK, 0, 1'b0, 1'b0, '0);

        // Hold reset, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < crit_row_idx; i++)
            send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].res);

        // Random episodes under three idle patterns
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = (ph == 0) ? 38 : (ph == 1) ? 53 : 0;
            snk_stall_pct = (ph == 0) ? 53 : (ph == 1) ? 38 : 0;
            phase_end     = sent_cnt + RANDOM_ITEMS / 3;
            while (sent_cnt < phase_end) begin
                if ($urandom_range(3) == 0)
                    send_event(noise_event(1'b0), 1'b0, '0);
                else
                    run_episode();
            end
        end

        for (int i = crit_row_idx; i < dir_rows.size(); i++)
            send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].res);
        repeat (20) send_event(noise_event(1'b1), 1'b0, '0);
        i_valid <= 1'b0;

        // Drain outstanding results
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Sent %0d events, checked %0d status words", sent_cnt, checked_cnt);
        $display("Saw %0d accepted acknowledges and %0d safe-off pulses",
                 ack_cnt, pulse_cnt);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ fault_latch_supervisor.f @@
sv/fls_pkg.sv
sv/fls_core.sv
sv/fault_latch_supervisor.sv
dv/tb_top.sv
